/* design/bmon_pkg.sv */
// Shared types and constants for the battery cell extreme monitor.
// No dependencies; used by battery_cell_extreme_monitor and its testbench.
`default_nettype none
package bmon_pkg;

  localparam int ModuleCountDef      = 5;
  localparam int CellsPerModuleDef   = 20;
  localparam int SensorsPerModuleDef = 18;

  localparam int ModW     = 3;
  localparam int PosW     = 5;
  localparam int ReadingW = 16;
  localparam int VoltW    = 15;
  localparam int SumW     = 22;

  // Starting point of the temperature minimum, 100.0 degC
  localparam logic signed [ReadingW-1:0] TempMinCap = 16'sd1000;

  localparam logic KIND_VOLTAGE = 1'b0;
  localparam logic KIND_TEMP    = 1'b1;

  typedef struct packed {
    logic                       kind;
    logic [ModW-1:0]            module_index;
    logic [PosW-1:0]            cell_index;
    logic signed [ReadingW-1:0] reading;
  } req_t;

  typedef struct packed {
    logic                       error;
    logic [SumW-1:0]            pack_voltage;
    logic [VoltW-1:0]           max_voltage;
    logic [ModW-1:0]            max_voltage_module;
    logic [PosW-1:0]            max_voltage_cell;
    logic [VoltW-1:0]           min_voltage;
    logic [ModW-1:0]            min_voltage_module;
    logic [PosW-1:0]            min_voltage_cell;
    logic [VoltW-1:0]           max_temp;
    logic [ModW-1:0]            max_temp_module;
    logic [PosW-1:0]            max_temp_sensor;
    logic signed [ReadingW-1:0] min_temp;
  } rsp_t;

endpackage
`default_nettype wire

/* design/bmon_cell.sv */
// One storage cell of a rotating ring: loads a written value or takes its neighbor's.
// Depends on nothing but the clock and reset.
`default_nettype none
module bmon_cell #(
  parameter int W = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         load,
  input  wire logic [W-1:0] load_data,
  input  wire logic         shift,
  input  wire logic [W-1:0] shift_in,
  output logic [W-1:0]      q
);

  // Hold, load a new reading, or advance from the neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (load) begin
      q <= load_data;
    end else if (shift) begin
      q <= shift_in;
    end
  end

endmodule
`default_nettype wire

/* design/battery_cell_extreme_monitor.sv */
// Battery cell extreme monitor.
// Requests arrive on req (valid/ready); each writes one cell voltage or one
// thermistor temperature into its store and yields exactly one result on rsp.
// A result carries the pack voltage sum, the largest and smallest voltages with
// their locations, the highest temperature with its location and the lowest
// temperature. An out-of-range module or position stores nothing and sets error.
// Both stores are rings of cells that rotate once per request past a scan unit
// at the head of the ring. The scan covers the larger of the two rings,
// MODULE_COUNT*CELLS_PER_MODULE voltage cells or MODULE_COUNT*SENSORS_PER_MODULE
// sensor cells, and the result is then loaded from the done state. One request is
// in work at a time; req_ready is high only while the block is idle.
// A result waits in the output register while rsp_ready is low; the scan of
// the next request cannot finish into it until it has been taken.
// Synchronous reset clears every stored reading to zero and drops rsp_valid.
// Depends on bmon_pkg and bmon_cell.
`default_nettype none
module battery_cell_extreme_monitor
  import bmon_pkg::*;
#(
  parameter int MODULE_COUNT       = ModuleCountDef,
  parameter int CELLS_PER_MODULE   = CellsPerModuleDef,
  parameter int SENSORS_PER_MODULE = SensorsPerModuleDef
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  localparam int NV       = MODULE_COUNT * CELLS_PER_MODULE;
  localparam int NT       = MODULE_COUNT * SENSORS_PER_MODULE;
  localparam int SCAN_LEN = (NV > NT) ? NV : NT;
  localparam int CW       = $clog2(SCAN_LEN + 1);
  localparam int VIW      = $clog2(NV + 1);
  localparam int TIW      = $clog2(NT + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]    state;
  logic [CW-1:0] cnt;
  logic          err;

  logic [VoltW-1:0]    vq [NV];
  logic [ReadingW-1:0] tq [NT];

  // Decode the write
  logic             accept;
  logic             wr_v;
  logic             wr_t;
  logic [VIW-1:0]   v_idx;
  logic [TIW-1:0]   t_idx;
  logic [VoltW-1:0] v_clamped;
  logic             mod_ok;

  assign accept    = req_valid && req_ready;
  assign req_ready = (state == ST_IDLE);
  assign mod_ok    = 32'(req.module_index) < MODULE_COUNT;
  assign wr_v = accept && (req.kind == KIND_VOLTAGE) && mod_ok
              && (32'(req.cell_index) < CELLS_PER_MODULE);
  assign wr_t = accept && (req.kind == KIND_TEMP) && mod_ok
              && (32'(req.cell_index) < SENSORS_PER_MODULE);
  assign v_idx = VIW'(32'(req.module_index) * CELLS_PER_MODULE + 32'(req.cell_index));
  assign t_idx = TIW'(32'(req.module_index) * SENSORS_PER_MODULE + 32'(req.cell_index));
  assign v_clamped = req.reading[ReadingW-1] ? '0 : req.reading[VoltW-1:0];

  logic v_shift;
  logic t_shift;
  assign v_shift = (state == ST_SCAN) && (32'(cnt) < NV);
  assign t_shift = (state == ST_SCAN) && (32'(cnt) < NT);

  // Rings of cells; cell 0 is the head seen by the scan
  for (genvar i = 0; i < NV; i++) begin : g_vcell
    bmon_cell #(.W(VoltW)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .load      (wr_v && (v_idx == VIW'(i))),
      .load_data (v_clamped),
      .shift     (v_shift),
      .shift_in  (vq[(i + 1) % NV]),
      .q         (vq[i])
    );
  end

  for (genvar i = 0; i < NT; i++) begin : g_tcell
    bmon_cell #(.W(ReadingW)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .load      (wr_t && (t_idx == TIW'(i))),
      .load_data (req.reading),
      .shift     (t_shift),
      .shift_in  (tq[(i + 1) % NT]),
      .q         (tq[i])
    );
  end

  // Scan accumulators and location counters
  logic [SumW-1:0]            sum;
  logic [VoltW-1:0]           vmax;
  logic [ModW-1:0]            vmax_m;
  logic [PosW-1:0]            vmax_c;
  logic [VoltW:0]             vmin;
  logic [ModW-1:0]            vmin_m;
  logic [PosW-1:0]            vmin_c;
  logic signed [ReadingW-1:0] tmax;
  logic [ModW-1:0]            tmax_m;
  logic [PosW-1:0]            tmax_s;
  logic signed [ReadingW-1:0] tmin;
  logic [ModW-1:0]            vm;
  logic [PosW-1:0]            vp;
  logic [ModW-1:0]            tm;
  logic [PosW-1:0]            tp;

  logic signed [ReadingW-1:0] thead;
  assign thead = tq[0];

  always_ff @(posedge clk) begin
    if (accept) begin
      sum  <= '0;
      vmax <= '0; vmax_m <= '0; vmax_c <= '0;
      vmin <= '1; vmin_m <= '0; vmin_c <= '0;
      tmax <= '0; tmax_m <= '0; tmax_s <= '0;
      tmin <= TempMinCap;
      vm <= '0; vp <= '0; tm <= '0; tp <= '0;
    end else begin
      // Compare the voltage at the head, then advance its location
      if (v_shift) begin
        sum <= sum + SumW'(vq[0]);
        if (vq[0] > vmax) begin
          vmax <= vq[0]; vmax_m <= vm; vmax_c <= vp;
        end
        if ({1'b0, vq[0]} < vmin) begin
          vmin <= {1'b0, vq[0]}; vmin_m <= vm; vmin_c <= vp;
        end
        if (32'(vp) == CELLS_PER_MODULE - 1) begin
          vp <= '0;
          vm <= vm + 1'b1;
        end else begin
          vp <= vp + 1'b1;
        end
      end
      // Compare the temperature at the head, then advance its location
      if (t_shift) begin
        if (thead > tmax) begin
          tmax <= thead; tmax_m <= tm; tmax_s <= tp;
        end
        if (thead < tmin) begin
          tmin <= thead;
        end
        if (32'(tp) == SENSORS_PER_MODULE - 1) begin
          tp <= '0;
          tm <= tm + 1'b1;
        end else begin
          tp <= tp + 1'b1;
        end
      end
    end
  end

  // Sequence one request: write, scan a full turn, hand off the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if ((state == ST_DONE) && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_SCAN;
            cnt   <= '0;
          end
        end
        ST_SCAN: begin
          if (32'(cnt) == SCAN_LEN - 1) begin
            state <= ST_DONE;
          end
          cnt <= cnt + 1'b1;
        end
        ST_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Hold the error flag of the request in work
  always_ff @(posedge clk) begin
    if (accept) begin
      err <= !(wr_v || wr_t);
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && (!rsp_valid || rsp_ready)) begin
      rsp.error              <= err;
      rsp.pack_voltage       <= sum;
      rsp.max_voltage        <= vmax;
      rsp.max_voltage_module <= vmax_m;
      rsp.max_voltage_cell   <= vmax_c;
      rsp.min_voltage        <= vmin[VoltW-1:0];
      rsp.min_voltage_module <= vmin_m;
      rsp.min_voltage_cell   <= vmin_c;
      rsp.max_temp           <= tmax[VoltW-1:0];
      rsp.max_temp_module    <= tmax_m;
      rsp.max_temp_sensor    <= tmax_s;
      rsp.min_temp           <= tmin;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SCAN))
    else $error("accepted request did not start a scan");
  a_busy_no_ready: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !req_ready)
    else $error("request taken while busy");
  a_done_result: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DONE) && (!rsp_valid || rsp_ready)) |=> (rsp_valid && (state == ST_IDLE)))
    else $error("finished scan did not present a result");
  a_scan_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (32'(cnt) < SCAN_LEN))
    else $error("scan ran past a full turn");
`endif

endmodule
`default_nettype wire

/* verif/tb_battery_cell_extreme_monitor.sv */
// Testbench for the battery cell extreme monitor: random and directed readings,
// a local store model that predicts every result, and a whole-result compare.
// Depends on bmon_pkg and battery_cell_extreme_monitor.
`default_nettype none
module tb_battery_cell_extreme_monitor;
  import bmon_pkg::*;

  localparam int NMod  = ModuleCountDef;
  localparam int NCell = CellsPerModuleDef;
  localparam int NSens = SensorsPerModuleDef;
  localparam int NRandom = 1130;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  battery_cell_extreme_monitor dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the stores
  logic [VoltW-1:0]           volt_mem [NMod][NCell];
  logic signed [ReadingW-1:0] temp_mem [NMod][NSens];
  logic [SumW-1:0]            pack_total;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   errors = 0;
  bit   stim_done = 1'b0;
  bit   quiet = 1'b0;
  int   send_gap = 0;
  int   take_gap = 0;

  // Apply one request to the store copy and compute the result
  function automatic rsp_t apply_reading(req_t r);
    rsp_t o;
    int vmax, vmin, tmax, tmin, v, t;
    o = '0;
    if (r.kind == KIND_VOLTAGE) begin
      if (r.module_index < NMod && r.cell_index < NCell) begin
        v = (r.reading < 0) ? 0 : int'(r.reading);
        pack_total = SumW'(pack_total - volt_mem[r.module_index][r.cell_index] + v);
        volt_mem[r.module_index][r.cell_index] = v[VoltW-1:0];
      end else begin
        o.error = 1'b1;
      end
    end else begin
      if (r.module_index < NMod && r.cell_index < NSens)
        temp_mem[r.module_index][r.cell_index] = r.reading;
      else
        o.error = 1'b1;
    end
    vmax = 0; vmin = 100000; tmax = 0; tmin = 1000;
    for (int m = 0; m < NMod; m++) begin
      for (int c = 0; c < NCell; c++) begin
        v = int'(volt_mem[m][c]);
        if (v > vmax) begin
          vmax = v; o.max_voltage_module = ModW'(m); o.max_voltage_cell = PosW'(c);
        end
        if (v < vmin) begin
          vmin = v; o.min_voltage_module = ModW'(m); o.min_voltage_cell = PosW'(c);
        end
      end
      for (int s = 0; s < NSens; s++) begin
        t = int'(temp_mem[m][s]);
        if (t > tmax) begin
          tmax = t; o.max_temp_module = ModW'(m); o.max_temp_sensor = PosW'(s);
        end
        if (t < tmin) tmin = t;
      end
    end
    o.pack_voltage = pack_total;
    o.max_voltage = vmax[VoltW-1:0];
    o.min_voltage = vmin[VoltW-1:0];
    o.max_temp = tmax[VoltW-1:0];
    o.min_temp = tmin[ReadingW-1:0];
    return o;
  endfunction

  // Driver: present queued requests, idle in bursts
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) begin
        expected_rsps.push_back(apply_reading(req));
      end
      if (!req_valid || req_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          req_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req <= pending_reqs.pop_front();
          req_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 3) == 0) send_gap <= $urandom_range(1, 10);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each taken result with the oldest expectation
  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result %p", $time, rsp);
          errors++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (rsp !== exp_rsp) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp_rsp, rsp);
            errors++;
          end
        end
      end
      if (take_gap > 0) begin
        take_gap <= take_gap - 1;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) take_gap <= $urandom_range(1, 10);
      end
    end
  end

  function automatic req_t make_req(logic k, int m, int c, int r);
    req_t q;
    q.kind = k;
    q.module_index = m[ModW-1:0];
    q.cell_index = c[PosW-1:0];
    q.reading = r[ReadingW-1:0];
    return q;
  endfunction

  // Stimulus
  initial begin
    int roll, rd;
    foreach (volt_mem[m, c]) volt_mem[m][c] = '0;
    foreach (temp_mem[m, s]) temp_mem[m][s] = '0;
    pack_total = '0;
    // Directed: extremes, clamping, bounds, ties, min cap
    pending_reqs.push_back(make_req(KIND_VOLTAGE, 0, 0, 0));
    pending_reqs.push_back(make_req(KIND_TEMP, 0, 0, 0));
    pending_reqs.push_back(make_req(KIND_VOLTAGE, 4, 19, 32767));
    pending_reqs.push_back(make_req(KIND_VOLTAGE, 2, 5, 32767));
    pending_reqs.push_back(make_req(KIND_VOLTAGE, 1, 3, -1));
    pending_reqs.push_back(make_req(KIND_VOLTAGE, 1, 4, -32768));
    pending_reqs.push_back(make_req(KIND_VOLTAGE, 5, 0, 1234));
    pending_reqs.push_back(make_req(KIND_VOLTAGE, 7, 31, 1234));
    pending_reqs.push_back(make_req(KIND_VOLTAGE, 0, 20, 1234));
    pending_reqs.push_back(make_req(KIND_TEMP, 0, 18, 500));
    pending_reqs.push_back(make_req(KIND_TEMP, 6, 3, 500));
    pending_reqs.push_back(make_req(KIND_TEMP, 4, 17, 32767));
    pending_reqs.push_back(make_req(KIND_TEMP, 3, 2, 32767));
    pending_reqs.push_back(make_req(KIND_TEMP, 2, 9, -32768));
    pending_reqs.push_back(make_req(KIND_TEMP, 2, 9, 1000));
    pending_reqs.push_back(make_req(KIND_TEMP, 0, 0, 999));
    pending_reqs.push_back(make_req(KIND_TEMP, 4, 17, -5));
    pending_reqs.push_back(make_req(KIND_TEMP, 3, 2, 0));
    pending_reqs.push_back(make_req(KIND_VOLTAGE, 4, 19, 0));
    pending_reqs.push_back(make_req(KIND_VOLTAGE, 2, 5, 0));
    // Random: mostly valid indexes, realistic and full-range readings
    for (int i = 0; i < NRandom; i++) begin
      roll = $urandom_range(0, 9);
      rd = (roll < 5) ? $urandom_range(2500, 4300) : $urandom_range(0, 65535);
      if (roll < 8) begin
        if ($urandom_range(0, 1) == 0)
          pending_reqs.push_back(make_req(KIND_VOLTAGE, $urandom_range(0, NMod - 1),
                                          $urandom_range(0, NCell - 1), rd));
        else
          pending_reqs.push_back(make_req(KIND_TEMP, $urandom_range(0, NMod - 1),
                                          $urandom_range(0, NSens - 1),
                                          (roll < 5) ? $urandom_range(0, 1200) - 200 : rd));
      end else begin
        pending_reqs.push_back(make_req($urandom_range(0, 1), $urandom_range(0, 7),
                                        $urandom_range(0, 31), rd));
      end
      if (i == NRandom - 100) quiet = 1'b0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // Drop idling for the last stretch of the run
    wait (pending_reqs.size() < 100);
    quiet = 1'b1;
    wait (pending_reqs.size() == 0 && !req_valid && expected_rsps.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #6000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
design/bmon_pkg.sv
design/bmon_cell.sv
design/battery_cell_extreme_monitor.sv
verif/tb_battery_cell_extreme_monitor.sv
